// ===== sv/svpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak bar-graph package
// Shared types, widths, constants and the logarithmic threshold table of the
// stereo peak bar-graph unit.
// ----------------------------------------------------------------------------
package svpb_pkg;

   localparam int SAMPLE_BITS     = 12;
   localparam int PEAK_FRAC_BITS  = 16;
   localparam int PEAK_BITS       = SAMPLE_BITS + PEAK_FRAC_BITS;
   localparam int LEVEL_BITS      = 7;
   localparam int BYTE_NUM_BITS   = 5;
   localparam int SHIFT_BITS      = 4;
   localparam int LEDS_PER_BYTE   = 7;
   localparam int THRESH_COUNT    = 70;
   localparam int LEVEL_STEPS_DEF = 70;
   localparam int FRAME_BYTES_DEF = 20;

   localparam logic [SHIFT_BITS-1:0]  DECAY_SHIFT_RESET = 4'd8;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE        = 12'd4095;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLDS [THRESH_COUNT] = '{
      12'd11,   12'd12,   12'd13,   12'd14,   12'd15,   12'd16,   12'd18,
      12'd19,   12'd21,   12'd23,   12'd25,   12'd27,   12'd30,   12'd33,
      12'd35,   12'd39,   12'd42,   12'd46,   12'd50,   12'd55,   12'd60,
      12'd65,   12'd71,   12'd77,   12'd84,   12'd92,   12'd100,  12'd109,
      12'd119,  12'd129,  12'd141,  12'd154,  12'd168,  12'd183,  12'd199,
      12'd217,  12'd237,  12'd258,  12'd282,  12'd307,  12'd335,  12'd365,
      12'd398,  12'd434,  12'd473,  12'd516,  12'd562,  12'd613,  12'd668,
      12'd728,  12'd794,  12'd865,  12'd944,  12'd1029, 12'd1121, 12'd1223,
      12'd1333, 12'd1453, 12'd1584, 12'd1727, 12'd1883, 12'd2052, 12'd2237,
      12'd2439, 12'd2659, 12'd2899, 12'd3160, 12'd3446, 12'd3756, 12'd4095
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECAY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left_sample;
      logic [SAMPLE_BITS-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic [7:0]               frame_byte;
      logic [BYTE_NUM_BITS-1:0] byte_number;
      logic [LEVEL_BITS-1:0]    left_level;
      logic [LEVEL_BITS-1:0]    right_level;
      logic                     last_byte;
   } rsp_type;

   // Entries past the stored table read as full scale.
   function automatic logic [SAMPLE_BITS-1:0] threshold(input logic [LEVEL_BITS-1:0] idx);
      logic [SAMPLE_BITS-1:0] t;
      if (int'(idx) < THRESH_COUNT) begin
         t = THRESHOLDS[idx];
      end else begin
         t = FULL_SCALE;
      end
      return t;
   endfunction

endpackage

// ===== sv/svpb_byte_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte builder
// Forms one LED driver byte of the frame from the two bar levels. Each byte
// carries seven LEDs in bits 1 to 7; the right bar starts at the middle byte.
// ----------------------------------------------------------------------------
module svpb_byte_builder #(
   parameter int FRAME_BYTES = svpb_pkg::FRAME_BYTES_DEF
) (
   input  logic [$clog2(FRAME_BYTES)-1:0]     byte_index,
   input  logic [svpb_pkg::LEVEL_BITS-1:0]    left_level,
   input  logic [svpb_pkg::LEVEL_BITS-1:0]    right_level,
   output logic [7:0]                         frame_byte
);

   localparam int ByteW = $clog2(FRAME_BYTES);
   localparam int Half  = FRAME_BYTES / 2;
   localparam int SpanW = ByteW + 3;
   localparam int LedW  = (SpanW > svpb_pkg::LEVEL_BITS) ? SpanW : svpb_pkg::LEVEL_BITS;
   localparam int Leds  = svpb_pkg::LEDS_PER_BYTE;

   logic             right_active;
   logic [ByteW-1:0] right_group;
   logic [Leds-1:0]  left_bits;
   logic [Leds-1:0]  right_bits;

   function automatic logic [Leds-1:0] bar_bits(input logic [svpb_pkg::LEVEL_BITS-1:0] level,
                                                input logic [ByteW-1:0] group);
      logic [LedW-1:0] first;
      logic [Leds-1:0] mask;
      first = LedW'(SpanW'(group) * SpanW'(Leds));
      for (int n = 0; n < Leds; n++) begin
         mask[n] = (first + LedW'(n)) < LedW'(level);
      end
      return mask;
   endfunction

   assign right_active = byte_index >= ByteW'(Half);
   assign right_group  = byte_index - ByteW'(Half);
   assign left_bits    = bar_bits(left_level, byte_index);
   assign right_bits   = right_active ? bar_bits(right_level, right_group) : '0;
   assign frame_byte   = {left_bits | right_bits, 1'b0};

endmodule

// ===== sv/stereo_vu_meter_peak_bargraph_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak bar-graph unit
// Holds a decaying peak per channel, maps each peak to an LED count through a
// logarithmic threshold table and sends the bar-graph frame byte by byte.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  req_data (left/right sample)
//  rsp       out        rsp_valid / rsp_stall  rsp_data (one frame byte)
//  csr       in         csr_wr_en              csr_wr_data (decay shift)
//
// A sample pair passes through acceptance, the left and right threshold scans,
// the two decay steps and then FRAME_BYTES result beats, in that order.
// The threshold scan uses one comparator, one table entry per cycle, and the
// two peaks decay one after the other through a single shifter and subtractor.
// Reset clears both peaks and sets the decay shift to 8.
// A stalled result beat holds the sequencer; no sample is taken until the
// final beat of the frame has been loaded into the output register.
// ----------------------------------------------------------------------------
module stereo_vu_meter_peak_bargraph_unit #(
   parameter int LEVEL_STEPS = svpb_pkg::LEVEL_STEPS_DEF,
   parameter int FRAME_BYTES = svpb_pkg::FRAME_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  svpb_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output svpb_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [svpb_pkg::SHIFT_BITS-1:0] csr_wr_data
);

   localparam int IdxW  = $clog2(LEVEL_STEPS);
   localparam int ByteW = $clog2(FRAME_BYTES);
   localparam int LvlW  = svpb_pkg::LEVEL_BITS;
   localparam int PeakW = svpb_pkg::PEAK_BITS;
   localparam int SmpW  = svpb_pkg::SAMPLE_BITS;
   localparam int NumW  = svpb_pkg::BYTE_NUM_BITS;

   svpb_pkg::state_type state_ff, state_in;

   logic                             chan_ff, chan_in;
   logic [IdxW-1:0]                  idx_ff, idx_in;
   logic [PeakW-1:0]                 left_peak_ff, left_peak_in;
   logic [PeakW-1:0]                 right_peak_ff, right_peak_in;
   logic [LvlW-1:0]                  left_level_ff, left_level_in;
   logic [LvlW-1:0]                  right_level_ff, right_level_in;
   logic [ByteW-1:0]                 byte_ff, byte_in;
   logic [svpb_pkg::SHIFT_BITS-1:0]  decay_shift_ff, decay_shift_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   svpb_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             scan_step;
   logic             decay_step;
   logic             load_beat;

   logic [PeakW-1:0] left_new;
   logic [PeakW-1:0] right_new;
   logic [SmpW-1:0]  scan_value;
   logic [SmpW-1:0]  scan_thresh;
   logic             scan_hit;
   logic             scan_end;
   logic             scan_done;
   logic [LvlW-1:0]  found_level;
   logic [PeakW-1:0] decay_src;
   logic [PeakW-1:0] decay_res;
   logic [7:0]       built_byte;

   // Datapath
   assign left_new  = {req_data.left_sample, svpb_pkg::PEAK_FRAC_BITS'(0)};
   assign right_new = {req_data.right_sample, svpb_pkg::PEAK_FRAC_BITS'(0)};

   assign scan_value  = chan_ff ? right_peak_ff[PeakW-1 -: SmpW] : left_peak_ff[PeakW-1 -: SmpW];
   assign scan_thresh = svpb_pkg::threshold(LvlW'(idx_ff));
   assign scan_hit    = scan_value < scan_thresh;
   assign scan_end    = idx_ff == IdxW'(LEVEL_STEPS - 1);
   assign scan_done   = scan_hit || scan_end;

   always_comb begin
      priority if (!scan_hit) begin
         found_level = LvlW'(LEVEL_STEPS - 1);
      end else if (idx_ff <= IdxW'(1)) begin
         found_level = LvlW'(1);
      end else begin
         found_level = LvlW'(idx_ff - IdxW'(1));
      end
   end

   assign decay_src = chan_ff ? right_peak_ff : left_peak_ff;
   assign decay_res = decay_src - (decay_src >> decay_shift_ff);

   svpb_byte_builder #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_byte_builder (
      .byte_index  (byte_ff),
      .left_level  (left_level_ff),
      .right_level (right_level_ff),
      .frame_byte  (built_byte)
   );

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         svpb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = svpb_pkg::ST_SCAN;
            end
         end
         svpb_pkg::ST_SCAN: begin
            if (scan_done && chan_ff) begin
               state_in = svpb_pkg::ST_DECAY;
            end
         end
         svpb_pkg::ST_DECAY: begin
            if (chan_ff) begin
               state_in = svpb_pkg::ST_EMIT;
            end
         end
         svpb_pkg::ST_EMIT: begin
            if (load_beat && byte_ff == '0) begin
               state_in = svpb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = svpb_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      accept     = 1'b0;
      scan_step  = 1'b0;
      decay_step = 1'b0;
      load_beat  = 1'b0;
      unique case (state_ff)
         svpb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         svpb_pkg::ST_SCAN: begin
            scan_step = 1'b1;
         end
         svpb_pkg::ST_DECAY: begin
            decay_step = 1'b1;
         end
         svpb_pkg::ST_EMIT: begin
            load_beat = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Register next values
   always_comb begin
      chan_in        = chan_ff;
      idx_in         = idx_ff;
      left_peak_in   = left_peak_ff;
      right_peak_in  = right_peak_ff;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      byte_in        = byte_ff;
      decay_shift_in = csr_wr_en ? csr_wr_data : decay_shift_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      if (accept) begin
         chan_in = 1'b0;
         idx_in  = '0;
         if (left_new > left_peak_ff) begin
            left_peak_in = left_new;
         end
         if (right_new > right_peak_ff) begin
            right_peak_in = right_new;
         end
      end

      if (scan_step) begin
         if (scan_done) begin
            idx_in  = '0;
            chan_in = !chan_ff;
            if (chan_ff) begin
               right_level_in = found_level;
            end else begin
               left_level_in = found_level;
            end
         end else begin
            idx_in = idx_ff + IdxW'(1);
         end
      end

      if (decay_step) begin
         chan_in = !chan_ff;
         byte_in = ByteW'(FRAME_BYTES - 1);
         if (chan_ff) begin
            right_peak_in = decay_res;
         end else begin
            left_peak_in = decay_res;
         end
      end

      if (load_beat) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.frame_byte  = built_byte;
         rsp_data_in.byte_number = NumW'(byte_ff);
         rsp_data_in.left_level  = left_level_ff;
         rsp_data_in.right_level = right_level_ff;
         rsp_data_in.last_byte   = byte_ff == '0;
         byte_in                 = byte_ff - ByteW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= svpb_pkg::ST_IDLE;
         chan_ff        <= 1'b0;
         idx_ff         <= '0;
         left_peak_ff   <= '0;
         right_peak_ff  <= '0;
         byte_ff        <= '0;
         decay_shift_ff <= svpb_pkg::DECAY_SHIFT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chan_ff        <= chan_in;
         idx_ff         <= idx_in;
         left_peak_ff   <= left_peak_in;
         right_peak_ff  <= right_peak_in;
         byte_ff        <= byte_in;
         decay_shift_ff <= decay_shift_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_level_ff  <= left_level_in;
      right_level_ff <= right_level_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/svpb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak bar-graph checker
// Port-level checks of the stereo peak bar-graph unit, bound to the top level.
// ----------------------------------------------------------------------------
module svpb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input svpb_pkg::rsp_type               rsp_data
);

   // A sample pair occupies the unit, so the next cycle never takes another.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample beat accepted on consecutive cycles");

   // Every bar shows at least one LED.
   a_levels_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.left_level != '0 && rsp_data.right_level != '0)
      else $error("bar level of zero on a result beat");

   // Bit 0 of every driver byte is unused.
   a_bit0_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.frame_byte[0])
      else $error("unused bit 0 set in frame byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

endmodule

bind stereo_vu_meter_peak_bargraph_unit svpb_checker u_svpb_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak bar-graph unit testbench
// Drives sample pairs through the unit and checks every frame byte beat.
// A scoreboard class predicts the frame bytes from its own copy of the peaks
// and the decay shift. The run has a short directed part, then four random
// phases with different decay shifts and different sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAME_BYTES   = svpb_pkg::FRAME_BYTES_DEF;
   localparam int LEVEL_STEPS   = svpb_pkg::LEVEL_STEPS_DEF;
   localparam int SMP_BITS      = svpb_pkg::SAMPLE_BITS;
   localparam int PK_BITS       = svpb_pkg::PEAK_BITS;
   localparam int SH_BITS       = svpb_pkg::SHIFT_BITS;
   localparam int LVL_BITS      = svpb_pkg::LEVEL_BITS;
   localparam int LEDS          = svpb_pkg::LEDS_PER_BYTE;
   localparam int PHASE_ITEMS   = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = 2 * LEVEL_STEPS + FRAME_BYTES + 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_PRINTED   = 40;

   class bargraph_scoreboard;
      logic [PK_BITS-1:0]    left_hold   = '0;
      logic [PK_BITS-1:0]    right_hold  = '0;
      logic [SH_BITS-1:0]    decay_shift = svpb_pkg::DECAY_SHIFT_RESET;
      svpb_pkg::rsp_type     expected_bytes[$];
      int                    error_count = 0;

      function logic [LVL_BITS-1:0] led_count(logic [PK_BITS-1:0] hold);
         logic [SMP_BITS-1:0] whole;
         logic [SMP_BITS-1:0] step_level;
         int idx;
         int count;
         whole = hold[PK_BITS-1 -: SMP_BITS];
         count = LEVEL_STEPS - 1;
         for (idx = LEVEL_STEPS - 1; idx >= 0; idx--) begin
            step_level = (idx < svpb_pkg::THRESH_COUNT) ? svpb_pkg::THRESHOLDS[idx]
                                                        : svpb_pkg::FULL_SCALE;
            if (whole < step_level) begin
               count = (idx <= 1) ? 1 : idx - 1;
            end
         end
         return LVL_BITS'(count);
      endfunction

      function void note_pair(svpb_pkg::req_type pair);
         logic [PK_BITS-1:0]       left_in;
         logic [PK_BITS-1:0]       right_in;
         logic [8*FRAME_BYTES-1:0] leds;
         logic [LVL_BITS-1:0]      left_count;
         logic [LVL_BITS-1:0]      right_count;
         svpb_pkg::rsp_type        beat;
         int k;
         int pos;
         int n;
         left_in  = {pair.left_sample, {svpb_pkg::PEAK_FRAC_BITS{1'b0}}};
         right_in = {pair.right_sample, {svpb_pkg::PEAK_FRAC_BITS{1'b0}}};
         if (left_in > left_hold) begin
            left_hold = left_in;
         end
         if (right_in > right_hold) begin
            right_hold = right_in;
         end
         left_count  = led_count(left_hold);
         right_count = led_count(right_hold);
         leds = '0;
         for (k = 0; k < left_count; k++) begin
            pos = 1 + 8 * (k / LEDS) + (k % LEDS);
            if (pos < 8 * FRAME_BYTES) begin
               leds[pos] = 1'b1;
            end
         end
         for (k = 0; k < right_count; k++) begin
            pos = 1 + 8 * (FRAME_BYTES / 2) + 8 * (k / LEDS) + (k % LEDS);
            if (pos < 8 * FRAME_BYTES) begin
               leds[pos] = 1'b1;
            end
         end
         for (n = FRAME_BYTES - 1; n >= 0; n--) begin
            beat.frame_byte  = leds[8*n +: 8];
            beat.byte_number = svpb_pkg::BYTE_NUM_BITS'(n);
            beat.left_level  = left_count;
            beat.right_level = right_count;
            beat.last_byte   = (n == 0);
            expected_bytes.push_back(beat);
         end
         left_hold  = left_hold - (left_hold >> decay_shift);
         right_hold = right_hold - (right_hold >> decay_shift);
      endfunction

      task report(string what);
         error_count++;
         if (error_count <= MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
      endtask

      task check_byte(svpb_pkg::rsp_type got);
         svpb_pkg::rsp_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("beat %h arrived with nothing expected", got));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte) begin
            report($sformatf("byte %0d: frame_byte %h, expected %h",
                             want.byte_number, got.frame_byte, want.frame_byte));
         end
         if (got.byte_number !== want.byte_number) begin
            report($sformatf("byte_number %0d, expected %0d",
                             got.byte_number, want.byte_number));
         end
         if (got.left_level !== want.left_level) begin
            report($sformatf("byte %0d: left_level %0d, expected %0d",
                             want.byte_number, got.left_level, want.left_level));
         end
         if (got.right_level !== want.right_level) begin
            report($sformatf("byte %0d: right_level %0d, expected %0d",
                             want.byte_number, got.right_level, want.right_level));
         end
         if (got.last_byte !== want.last_byte) begin
            report($sformatf("byte %0d: last_byte %b, expected %b",
                             want.byte_number, got.last_byte, want.last_byte));
         end
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   svpb_pkg::req_type     req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   svpb_pkg::rsp_type     rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [SH_BITS-1:0]    csr_wr_data = '0;

   int                    send_pct    = 0;
   int                    stall_pct   = 0;
   int unsigned           cycle_count = 0;
   bargraph_scoreboard    sb;

   stereo_vu_meter_peak_bargraph_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_byte(rsp_data);
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic logic [SMP_BITS-1:0] random_level();
      int width;
      width = $urandom_range(0, SMP_BITS + 1);
      if (width >= SMP_BITS) begin
         return SMP_BITS'($urandom);
      end
      return SMP_BITS'($urandom_range(0, (1 << width) - 1));
   endfunction

   task automatic send_pair(input logic [SMP_BITS-1:0] left_in,
                            input logic [SMP_BITS-1:0] right_in);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{left_sample: left_in, right_sample: right_in};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_pair(req_data);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.expected_bytes.size() != 0);
   endtask

   task automatic write_decay(input logic [SH_BITS-1:0] shift);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= shift;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.decay_shift = shift;
   endtask

   initial begin
      int                    phase;
      int                    sent;
      int                    run;
      int                    burst;
      bit                    paused;
      logic [SH_BITS-1:0]    shift;
      logic [SMP_BITS-1:0]   loud;

      sb = new;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Threshold edges and full scale with the reset decay shift.
      send_pair(0, 0);
      send_pair(10, 11);
      send_pair(11, 12);
      send_pair(12, 13);
      send_pair(13, 14);
      send_pair(3755, 3756);
      send_pair(4094, 4095);
      send_pair(0, 0);
      send_pair(4095, 0);
      send_pair(0, 4095);
      send_pair(2048, 1);

      // A zero shift clears the whole peak in one step.
      write_decay(0);
      send_pair(4095, 4095);
      send_pair(0, 0);
      send_pair(1, 4095);
      send_pair(4095, 1);

      write_decay(15);
      send_pair(4095, 4095);
      send_pair(0, 0);
      send_pair(0, 0);

      write_decay(1);
      send_pair(4095, 0);
      send_pair(0, 0);
      send_pair(0, 0);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: shift = 3;
            1: shift = 15;
            2: shift = SH_BITS'($urandom_range(2, 14));
            default: shift = SH_BITS'($urandom_range(0, 15));
         endcase
         write_decay(shift);
         case (phase)
            0: begin
               send_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               send_pct  = 72;
               stall_pct = 0;
            end
            2: begin
               send_pct  = 0;
               stall_pct = 72;
            end
            default: begin
               send_pct  = 15;
               stall_pct = 15;
            end
         endcase
         paused = 1'b0;
         sent   = 0;
         while (sent < PHASE_ITEMS) begin
            if (!paused && sent >= PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            case ($urandom_range(0, 9))
               7: begin
                  // A quiet stretch lets both held peaks fall away.
                  run = $urandom_range(3, 8);
                  for (burst = 0; burst < run; burst++) begin
                     send_pair(SMP_BITS'($urandom_range(0, 15)),
                               SMP_BITS'($urandom_range(0, 15)));
                  end
                  sent += run;
               end
               8: begin
                  loud = SMP_BITS'($urandom_range(2048, 4095));
                  send_pair(loud, random_level());
                  sent++;
               end
               9: begin
                  loud = SMP_BITS'($urandom_range(2048, 4095));
                  send_pair(random_level(), loud);
                  sent++;
               end
               default: begin
                  send_pair(random_level(), random_level());
                  sent++;
               end
            endcase
         end
      end

      drain_results();
      repeat (END_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_bytes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/svpb_pkg.sv
sv/svpb_byte_builder.sv
sv/stereo_vu_meter_peak_bargraph_unit.sv
sv/svpb_checker.sv
verif/testbench.sv
